/* hdl/kpu_pkg.sv */
`timescale 1ns / 1ps
package kpu_pkg;

	localparam int MAX_N_DEF = 12;
	localparam int SIZE_W = 4;
	localparam int RANK_W = 29;
	localparam int ELEM_W = 4;
	localparam int FACT_W = RANK_W + 1;

	// A factorial at or above 2**RANK_W is clamped there; no rank reaches it.
	localparam logic [FACT_W-1:0] FACT_SAT = FACT_W'(1) << RANK_W;

	typedef struct packed {
		logic load;
		logic sub;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic ge;
		logic last;
		logic out_free;
	} sts_t;

	function automatic logic [FACT_W-1:0] fact_sat(input logic [SIZE_W-1:0] m);
		logic [FACT_W-1:0] f;
		case (m)
			4'd0: f = FACT_W'(1);
			4'd1: f = FACT_W'(1);
			4'd2: f = FACT_W'(2);
			4'd3: f = FACT_W'(6);
			4'd4: f = FACT_W'(24);
			4'd5: f = FACT_W'(120);
			4'd6: f = FACT_W'(720);
			4'd7: f = FACT_W'(5040);
			4'd8: f = FACT_W'(40320);
			4'd9: f = FACT_W'(362880);
			4'd10: f = FACT_W'(3628800);
			4'd11: f = FACT_W'(39916800);
			4'd12: f = FACT_W'(479001600);
			default: f = FACT_SAT;
		endcase
		return f;
	endfunction

endpackage

/* hdl/kth_permutation_unrank_core.sv */
`timescale 1ns / 1ps
// Permutation unranking core. An input beat carries a set size n and a one-based
// rank k; the core returns the k-th permutation of 1..n in lexicographic order,
// one element per output beat, with last set on the n-th beat.
// A rank of zero or above n!, or a set size of zero or above MAX_N, gives a
// single beat with element 0, last 1 and bad_rank 1.
// Both channels use valid/ready. One item is worked on at a time: in_ready is
// high only while the core is idle, but the last element may still be waiting
// in the output register when the next item is taken.
// Each element's factorial digit q is found by repeated subtraction of (m-1)!
// from the rank; the list removal takes place in the same cycle the element
// is written to the output register. When the receiver stalls, the core holds
// in its emit state until the output register frees up. Reset clears the
// controller and the valid flag of the output register.
module kth_permutation_unrank_core #(
	parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [kpu_pkg::SIZE_W-1:0]  set_size,
	input  logic [kpu_pkg::RANK_W-1:0]  rank,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kpu_pkg::ELEM_W-1:0]  element,
	output logic                        last,
	output logic                        bad_rank
);

	kpu_pkg::cmd_t cmd;
	kpu_pkg::sts_t sts;

	kpu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kpu_dpath #(
		.MAX_N (MAX_N)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.set_size  (set_size),
		.rank      (rank),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.element   (element),
		.last      (last),
		.bad_rank  (bad_rank)
	);

	a_bad_beat : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_rank |-> last && element == '0)
		else $error("bad-rank beat must be a lone last beat with element zero");

	a_leave_idle : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("core stayed ready after taking an item");

	a_good_elem : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_rank |-> element != '0 && 32'(element) <= MAX_N)
		else $error("permutation element out of range");

	a_one_cmd : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.sub, cmd.emit}))
		else $error("controller issued conflicting commands");

endmodule

/* hdl/kpu_ctrl.sv */
`timescale 1ns / 1ps
module kpu_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  kpu_pkg::sts_t sts,
	output kpu_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.ge) begin
					cmd.sub = 1'b1;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.last ? S_IDLE : S_DIV;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/kpu_dpath.sv */
`timescale 1ns / 1ps
module kpu_dpath #(
	parameter int MAX_N = kpu_pkg::MAX_N_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [kpu_pkg::SIZE_W-1:0]  set_size,
	input  logic [kpu_pkg::RANK_W-1:0]  rank,
	input  kpu_pkg::cmd_t               cmd,
	output kpu_pkg::sts_t               sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kpu_pkg::ELEM_W-1:0]  element,
	output logic                        last,
	output logic                        bad_rank
);

	localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	logic [kpu_pkg::ELEM_W-1:0] list_q [MAX_N];
	logic [kpu_pkg::SIZE_W-1:0] count_q;
	logic                       bad_q;
	logic [kpu_pkg::RANK_W-1:0] r_q;
	logic [kpu_pkg::FACT_W-1:0] f_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       out_valid_q;
	logic [kpu_pkg::ELEM_W-1:0] element_q;
	logic                       last_q;
	logic                       bad_rank_q;
	logic                       in_bad;

	assign in_bad = (set_size == '0) || (32'(set_size) > MAX_N) || (rank == '0) ||
		({1'b0, rank} > kpu_pkg::fact_sat(set_size));

	assign sts.ge = !bad_q && ({1'b0, r_q} >= f_q);
	assign sts.last = bad_q || (count_q == kpu_pkg::SIZE_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				bad_q <= in_bad;
				count_q <= in_bad ? '0 : set_size;
			end else if (cmd.emit) begin
				bad_q <= 1'b0;
				count_q <= bad_q ? '0 : count_q - kpu_pkg::SIZE_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Quotient digits come from repeated subtraction; idx_q counts the subtractions.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_N; i++) begin
				list_q[i] <= kpu_pkg::ELEM_W'(i + 1);
			end
			r_q <= rank - kpu_pkg::RANK_W'(1);
			f_q <= kpu_pkg::fact_sat(set_size - kpu_pkg::SIZE_W'(1));
			idx_q <= '0;
		end else if (cmd.sub) begin
			r_q <= r_q - f_q[kpu_pkg::RANK_W-1:0];
			idx_q <= idx_q + IDX_W'(1);
		end else if (cmd.emit) begin
			for (int i = 0; i < MAX_N - 1; i++) begin
				if (IDX_W'(i) >= idx_q) begin
					list_q[i] <= list_q[i + 1];
				end
			end
			f_q <= kpu_pkg::fact_sat(count_q - kpu_pkg::SIZE_W'(2));
			idx_q <= '0;
		end
		if (cmd.emit) begin
			element_q <= bad_q ? '0 : list_q[idx_q];
			last_q <= sts.last;
			bad_rank_q <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign element = element_q;
	assign last = last_q;
	assign bad_rank = bad_rank_q;

endmodule

/* verif/kth_permutation_unrank_core_test.sv */
`timescale 1ns / 1ps
module kth_permutation_unrank_core_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 206;
	localparam int MAX_PRINTED = 200;

	typedef struct {
		logic [kpu_pkg::ELEM_W-1:0] element;
		logic                       last;
		logic                       bad_rank;
	} perm_beat_t;

	class unrank_scoreboard;
		perm_beat_t expected_beats[$];
		int         errors;
		int         beat_count;

		function longint unsigned fact(int m);
			longint unsigned p;
			p = 1;
			for (int i = 2; i <= m; i++)
				p = p * i;
			return p;
		endfunction

		// Unranks in the factorial number system: each digit of the zero-based
		// rank picks one element from what is still left in the pool.
		function void note_input(logic [kpu_pkg::SIZE_W-1:0] n,
			logic [kpu_pkg::RANK_W-1:0] k);
			perm_beat_t                 b;
			logic [kpu_pkg::ELEM_W-1:0] pool[$];
			longint unsigned            f;
			longint unsigned            z;
			int                         idx;
			if (n == 0 || n > kpu_pkg::MAX_N_DEF || k == 0 || k > fact(n)) begin
				b.element = '0;
				b.last = 1'b1;
				b.bad_rank = 1'b1;
				expected_beats.push_back(b);
				return;
			end
			pool = {};
			for (int i = 1; i <= n; i++)
				pool.push_back(kpu_pkg::ELEM_W'(i));
			z = k - 1;
			for (int m = n; m > 0; m--) begin
				f = fact(m - 1);
				idx = int'(z / f);
				if (idx >= m)
					idx = m - 1;
				z = z % f;
				b.element = pool[idx];
				b.last = (m == 1);
				b.bad_rank = 1'b0;
				pool.delete(idx);
				expected_beats.push_back(b);
			end
		endfunction

		task report(string what);
			if (errors < MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [kpu_pkg::ELEM_W-1:0] element, logic last, logic bad_rank);
			perm_beat_t want;
			beat_count++;
			if (expected_beats.size() == 0) begin
				report($sformatf("output beat %0d arrived with nothing pending", beat_count));
				return;
			end
			want = expected_beats.pop_front();
			if (element !== want.element)
				report($sformatf("beat %0d element got %0d want %0d",
					beat_count, element, want.element));
			if (last !== want.last)
				report($sformatf("beat %0d last got %b want %b", beat_count, last, want.last));
			if (bad_rank !== want.bad_rank)
				report($sformatf("beat %0d bad_rank got %b want %b",
					beat_count, bad_rank, want.bad_rank));
		endtask

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [kpu_pkg::SIZE_W-1:0]   set_size;
	logic [kpu_pkg::RANK_W-1:0]   rank;
	logic                         out_valid;
	logic                         out_ready;
	logic [kpu_pkg::ELEM_W-1:0]   element;
	logic                         last;
	logic                         bad_rank;

	unrank_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int idle_cycles;

	kth_permutation_unrank_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.set_size  (set_size),
		.rank      (rank),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.element   (element),
		.last      (last),
		.bad_rank  (bad_rank)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Output checking and the no-progress watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(element, last, bad_rank);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no beat moved for %0d cycles", $time, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [kpu_pkg::SIZE_W-1:0] n,
		input logic [kpu_pkg::RANK_W-1:0] k);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		set_size <= n;
		rank <= k;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(n, k);
	endtask

	task automatic set_phase(input int item_idx, input int total);
		case (item_idx * 3 / total)
			0: begin
				send_idle_pct = 37;
				recv_idle_pct = 49;
			end
			1: begin
				send_idle_pct = 49;
				recv_idle_pct = 37;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic send_random_item();
		logic [kpu_pkg::SIZE_W-1:0] n;
		logic [kpu_pkg::RANK_W-1:0] k;
		longint unsigned            f;
		int                         pick;
		n = kpu_pkg::SIZE_W'($urandom_range(kpu_pkg::MAX_N_DEF, 1));
		f = sb.fact(n);
		pick = $urandom_range(99);
		if (pick < 8)
			k = kpu_pkg::RANK_W'(1);
		else if (pick < 16)
			k = kpu_pkg::RANK_W'(f);
		else if (pick < 80)
			k = kpu_pkg::RANK_W'($urandom_range(32'(f), 1));
		else if (pick < 86)
			k = '0;
		else if (pick < 93)
			k = kpu_pkg::RANK_W'($urandom_range(32'h1FFF_FFFF, 32'(f + 1)));
		else begin
			// Set size out of range: zero or above the list depth.
			n = ($urandom_range(3) == 0) ? kpu_pkg::SIZE_W'(0)
				: kpu_pkg::SIZE_W'($urandom_range(15, kpu_pkg::MAX_N_DEF + 1));
			k = kpu_pkg::RANK_W'($urandom());
		end
		send_item(n, k);
	endtask

	initial begin
		logic [kpu_pkg::SIZE_W-1:0] dir_size[] = '{1, 1, 1, 2, 2, 3, 3, 3, 3, 3, 3, 3, 4,
			12, 12, 12, 12, 12, 0, 0, 13, 15, 11, 5};
		logic [kpu_pkg::RANK_W-1:0] dir_rank[] = '{1, 0, 2, 1, 2, 1, 2, 3, 4, 5, 6, 7, 24, 1,
			479001600, 479001601, 29'h1FFF_FFFF, 239500800, 1, 0, 1, 29'h1FFF_FFFF,
			39916800, 0};
		int total;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		set_size = '0;
		rank = '0;
		out_ready = 1'b0;
		idle_cycles = 0;
		total = dir_size.size() + RANDOM_ITEMS;
		set_phase(0, total);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_size.size(); i++) begin
			set_phase(i, total);
			send_item(dir_size[i], dir_rank[i]);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			set_phase(dir_size.size() + i, total);
			send_random_item();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
